>>> rtl/core/text_to_integer_parser_defines.svh
// Assertion macros for the text to integer parser
`ifndef TEXT_TO_INTEGER_PARSER_DEFINES_SVH
`define TEXT_TO_INTEGER_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define TTI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tti: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define TTI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tti: next-cycle check failed");

`endif

>>> rtl/core/tti_pkg.sv
`timescale 1ns / 1ps

package tti_pkg;

  localparam int ChW       = 8;
  localparam int ValueW    = 64;
  localparam int BaseW     = 6;
  localparam int DigitW    = 6;
  localparam int ProdW     = ValueW + BaseW + 1;
  localparam int ConsumedW = 16;
  localparam int RegIdxW   = 1;
  localparam int CountBitsDef = 16;

  localparam logic [RegIdxW-1:0] RegRadix  = 1'd0;
  localparam logic [RegIdxW-1:0] RegSigned = 1'd1;

  localparam logic [BaseW-1:0] RadixReset = 6'd10;
  localparam logic [BaseW-1:0] Base8      = 6'd8;
  localparam logic [BaseW-1:0] Base10     = 6'd10;
  localparam logic [BaseW-1:0] Base16     = 6'd16;
  localparam logic [BaseW-1:0] RadixMax   = 6'd36;
  localparam logic [BaseW-1:0] RadixAuto  = 6'd0;
  localparam logic [BaseW-1:0] RadixOne   = 6'd1;
  localparam logic [DigitW-1:0] NoDigit   = 6'd63;

  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChCr    = 8'h0d;
  localparam logic [ChW-1:0] ChPlus  = 8'h2b;
  localparam logic [ChW-1:0] ChMinus = 8'h2d;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;
  localparam logic [ChW-1:0] ChLowA  = 8'h61;
  localparam logic [ChW-1:0] ChLowZ  = 8'h7a;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpZ   = 8'h5a;
  localparam logic [ChW-1:0] ChLowX  = 8'h78;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;

  localparam logic [ValueW-1:0] SignedMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] SignedMin = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic [ValueW-1:0] UnsMax    = {ValueW{1'b1}};

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhWs1    = 6'b000010,
    PhWs2    = 6'b000100,
    PhZero   = 6'b001000,
    PhZeroX  = 6'b010000,
    PhDigits = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ValueW-1:0]    value;
    logic [ConsumedW-1:0] consumed;
    logic                 overflowed;
    logic                 no_digits;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] a;
    logic [BaseW-1:0]  b;
    logic [DigitW-1:0] d;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

  function automatic logic is_blank(input logic [ChW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic [DigitW-1:0] digit_of(input logic [ChW-1:0] c);
    logic [DigitW-1:0] d;
    d = NoDigit;
    if ((c >= ChZero) && (c <= ChNine)) begin
      d = DigitW'(c - ChZero);
    end else if ((c >= ChLowA) && (c <= ChLowZ)) begin
      d = DigitW'(c - ChLowA) + DigitW'(10);
    end else if ((c >= ChUpA) && (c <= ChUpZ)) begin
      d = DigitW'(c - ChUpA) + DigitW'(10);
    end
    return d;
  endfunction

  function automatic logic [ValueW-1:0] limit_of(input logic sgn, input logic neg);
    logic [ValueW-1:0] l;
    l = UnsMax;
    if (sgn) begin
      l = neg ? SignedMin : SignedMax;
    end
    return l;
  endfunction

endpackage

>>> rtl/core/tti_if.sv
`timescale 1ns / 1ps

interface tti_chr_if;
  import tti_pkg::*;
  logic           valid;
  logic           ready;
  logic [ChW-1:0] ch;
  logic           first;
  modport source (output valid, ch, first, input ready);
  modport sink   (input valid, ch, first, output ready);
endinterface

interface tti_res_if;
  import tti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ValueW-1:0]    value;
  logic [ConsumedW-1:0] consumed;
  logic                 overflowed;
  logic                 no_digits;
  modport source (output valid, value, consumed, overflowed, no_digits, input ready);
  modport sink   (input valid, value, consumed, overflowed, no_digits, output ready);
endinterface

>>> rtl/core/tti_mul.sv
`timescale 1ns / 1ps

module tti_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tti_pkg::mul_req_t req_i,
  output tti_pkg::mul_rsp_t rsp_o
);
  import tti_pkg::*;

  localparam int AddStep  = BaseW;
  localparam int DoneStep = BaseW + 1;
  localparam int CntW     = $clog2(DoneStep + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] a_q, a_d;
  logic [BaseW-1:0]  b_q, b_d;
  logic [DigitW-1:0] d_q, d_d;
  logic [ProdW-1:0]  p_q, p_d;
  logic [ProdW-1:0]  sum_base;
  logic [ProdW-1:0]  sum_add;
  logic              add_step;
  logic              done;

  assign add_step = (cnt_q == CntW'(AddStep));
  assign done     = busy_q && (cnt_q == CntW'(DoneStep));

  // shared adder: shift-add over the base bits, then add the digit
  always_comb begin
    sum_base = add_step ? p_q : {p_q[ProdW-2:0], 1'b0};
    if (add_step) begin
      sum_add = ProdW'(d_q);
    end else if (b_q[BaseW-1]) begin
      sum_add = ProdW'(a_q);
    end else begin
      sum_add = '0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    p_d    = p_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      d_d    = req_i.d;
      p_d    = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      p_d   = sum_base + sum_add;
      b_d   = {b_q[BaseW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    d_q <= d_d;
    p_q <= p_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done;
  assign rsp_o.prod = p_q;

endmodule

>>> rtl/core/tti_parse.sv
`timescale 1ns / 1ps

module tti_parse #(
  parameter int CountBits = tti_pkg::CountBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [tti_pkg::ChW-1:0]  ch_i,
  input  logic                     first_i,
  input  logic [tti_pkg::BaseW-1:0] radix_i,
  input  logic                     signed_mode_i,
  output logic                     emit_o,
  output tti_pkg::res_t            res_o,
  output tti_pkg::mul_req_t        mul_req_o,
  input  tti_pkg::mul_rsp_t        mul_rsp_i
);
  import tti_pkg::*;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  phase_e               phase_q, w_phase;
  logic [ValueW-1:0]    accum_q, w_accum;
  logic                 sticky_q, w_sticky;
  logic                 neg_q, w_neg;
  logic [BaseW-1:0]     base_q, w_base;
  logic [CountBits-1:0] count_q, w_count;
  logic                 seen_q, w_seen;

  logic                 active;
  logic                 try_start;
  logic                 try_digit;
  logic                 do_emit;
  logic                 drop_last;
  logic                 do_mul;
  logic                 inc;
  logic [DigitW-1:0]    dig;
  logic [CountBits-1:0] cnt;
  logic [31:0]          cnt_ext;
  logic                 over;
  logic [ValueW-1:0]    fin_limit;

  assign dig    = digit_of(ch_i);
  assign active = first_i || (phase_q != PhIdle);

  always_comb begin
    w_phase   = first_i ? PhWs1 : phase_q;
    w_accum   = first_i ? '0 : accum_q;
    w_sticky  = first_i ? 1'b0 : sticky_q;
    w_neg     = first_i ? 1'b0 : neg_q;
    w_base    = first_i ? Base10 : base_q;
    w_count   = first_i ? '0 : count_q;
    w_seen    = first_i ? 1'b0 : seen_q;
    try_start = 1'b0;
    try_digit = 1'b0;
    do_emit   = 1'b0;
    drop_last = 1'b0;
    do_mul    = 1'b0;
    inc       = 1'b0;

    if (active) begin
      unique case (w_phase)
        PhIdle: begin
        end
        PhWs1: begin
          if (is_blank(ch_i)) begin
            inc = 1'b1;
          end else if ((ch_i == ChPlus) || (ch_i == ChMinus)) begin
            w_neg   = (ch_i == ChMinus);
            inc     = 1'b1;
            w_phase = PhWs2;
          end else begin
            try_start = 1'b1;
          end
        end
        PhWs2: begin
          if (is_blank(ch_i)) begin
            inc = 1'b1;
          end else begin
            try_start = 1'b1;
          end
        end
        PhZero: begin
          if ((ch_i == ChLowX) || (ch_i == ChUpX)) begin
            inc     = 1'b1;
            w_phase = PhZeroX;
          end else begin
            w_phase   = PhDigits;
            try_digit = 1'b1;
          end
        end
        PhZeroX: begin
          if (dig < Base16) begin
            w_base    = Base16;
            w_phase   = PhDigits;
            try_digit = 1'b1;
          end else begin
            do_emit   = 1'b1;
            drop_last = 1'b1;
          end
        end
        PhDigits: begin
          try_digit = 1'b1;
        end
        default: begin
          w_phase = PhIdle;
        end
      endcase
    end

    if (try_start) begin
      if ((radix_i == RadixOne) || (radix_i > RadixMax)) begin
        do_emit = 1'b1;
      end else if ((ch_i == ChZero) && ((radix_i == RadixAuto) || (radix_i == Base16))) begin
        w_base  = (radix_i == RadixAuto) ? Base8 : Base16;
        w_accum = '0;
        w_seen  = 1'b1;
        inc     = 1'b1;
        w_phase = PhZero;
      end else begin
        w_base    = (radix_i == RadixAuto) ? Base10 : radix_i;
        w_phase   = PhDigits;
        try_digit = 1'b1;
      end
    end

    if (try_digit) begin
      if ((dig >= w_base) || (w_base < Base8 && w_base < 6'd2)) begin
        do_emit = 1'b1;
      end else begin
        do_mul = 1'b1;
      end
    end

    if (inc && (w_count != CountMax)) begin
      w_count = w_count + CountBits'(1);
    end

    if (do_emit) begin
      w_phase = PhIdle;
    end
  end

  // result of an emitting character
  always_comb begin
    cnt = w_seen ? w_count : '0;
    if (drop_last && (cnt != CountMax) && (cnt != '0)) begin
      cnt = cnt - CountBits'(1);
    end
    cnt_ext = 32'(cnt);
    if (w_sticky) begin
      res_o.value = limit_of(signed_mode_i, w_neg);
    end else if (w_neg) begin
      res_o.value = ValueW'(0) - w_accum;
    end else begin
      res_o.value = w_accum;
    end
    res_o.consumed   = cnt_ext[ConsumedW-1:0];
    res_o.overflowed = w_sticky;
    res_o.no_digits  = !w_seen;
  end

  assign emit_o = do_emit;

  assign mul_req_o.start = fire_i && do_mul;
  assign mul_req_o.a     = w_accum;
  assign mul_req_o.b     = w_base;
  assign mul_req_o.d     = dig;

  assign fin_limit = limit_of(signed_mode_i, neg_q);
  assign over      = mul_rsp_i.prod > ProdW'(fin_limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      accum_q  <= '0;
      sticky_q <= 1'b0;
      neg_q    <= 1'b0;
      base_q   <= Base10;
      count_q  <= '0;
      seen_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= w_phase;
      accum_q  <= w_accum;
      sticky_q <= w_sticky;
      neg_q    <= w_neg;
      base_q   <= w_base;
      count_q  <= w_count;
      seen_q   <= w_seen;
    end else if (mul_rsp_i.done) begin
      if (over) begin
        sticky_q <= 1'b1;
      end else if (!sticky_q) begin
        accum_q <= mul_rsp_i.prod[ValueW-1:0];
      end
      seen_q <= 1'b1;
      if (count_q != CountMax) begin
        count_q <= count_q + CountBits'(1);
      end
    end
  end

endmodule

>>> rtl/core/text_to_integer_parser.sv
`timescale 1ns / 1ps
// Channel   Dir  Role    Payload
// chr_i     in   sink    ch, first
// res_o     out  source  value, consumed, overflowed, no_digits
// cfg_*_i   in   write   cfg_idx_i selects radix or signed_mode
//
// A blank, sign, prefix or terminating character does not use the multiplier.
// A digit is handled in steps: 6 shift-add passes of the shared 71-bit adder
// over the base bits, one pass adding the digit, one limit compare; no character is taken meanwhile.
// Reset clears the parse state and loads radix 10, unsigned mode.
// A character that ends a number is held off while the result register is full.

`include "text_to_integer_parser_defines.svh"

module text_to_integer_parser #(
  parameter int CountBits = tti_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tti_chr_if.sink                     chr_i,
  tti_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [tti_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [tti_pkg::BaseW-1:0]   cfg_data_i
);
  import tti_pkg::*;

  logic [BaseW-1:0] radix_val_q;
  logic             signed_q;
  logic             in_fire;
  logic             emit;
  res_t             res;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;
  logic             out_valid_q;
  res_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_val_q <= RadixReset;
      signed_q    <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegRadix) begin
        radix_val_q <= cfg_data_i;
      end else if (cfg_idx_i == RegSigned) begin
        signed_q <= cfg_data_i[0];
      end
    end
  end

  assign chr_i.ready = !mul_rsp.busy && (!out_valid_q || res_o.ready || !emit);
  assign in_fire     = chr_i.valid && chr_i.ready;

  tti_parse #(
    .CountBits(CountBits)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .ch_i         (chr_i.ch),
    .first_i      (chr_i.first),
    .radix_i      (radix_val_q),
    .signed_mode_i(signed_q),
    .emit_o       (emit),
    .res_o        (res),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp)
  );

  tti_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_q <= res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.value      = out_q.value;
  assign res_o.consumed   = out_q.consumed;
  assign res_o.overflowed = out_q.overflowed;
  assign res_o.no_digits  = out_q.no_digits;

  `TTI_ASSERT_IMP(a_busy_blocks_input, clk_i, rst_ni, mul_rsp.busy, !chr_i.ready)
  `TTI_ASSERT_IMP(a_emit_has_room, clk_i, rst_ni, in_fire && emit, !out_valid_q || res_o.ready)
  `TTI_ASSERT_NXT(a_digit_starts_unit, clk_i, rst_ni, mul_req.start, mul_rsp.busy)
  `TTI_ASSERT_NXT(a_no_spurious_result, clk_i, rst_ni, !out_valid_q && !(in_fire && emit), !out_valid_q)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tti_pkg::*;

  localparam logic [ChW-1:0] ChNul = 8'h00;
  localparam res_t NoResult = '0;
  localparam int PhaseCount = 12;
  localparam int CharsPerPhase = 125;
  localparam int SettleCycles = 16;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           first;
    logic           typed;
    res_t           want;
  } char_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RegIdxW-1:0] cfg_idx;
  logic [BaseW-1:0] cfg_data;

  tti_chr_if chr_bus ();
  tti_res_if res_bus ();

  text_to_integer_parser u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .chr_i      (chr_bus),
    .res_o      (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int chars_parsed;
  res_t expected_numbers[$];

  logic [BaseW-1:0] radix_reg;
  logic             signed_reg;

  phase_e               prs_phase;
  logic [ValueW-1:0]    prs_acc;
  logic                 prs_over;
  logic                 prs_neg;
  logic [BaseW-1:0]     prs_base;
  logic [ConsumedW-1:0] prs_count;
  logic                 prs_digit;

  int radix_plan [PhaseCount] = '{16, 10, 0, 2, 36, 0, 16, 1, 37, 63, 8, 36};
  int signed_plan [PhaseCount] = '{0, 0, 1, 1, 0, 0, 1, 0, 1, 0, 1, 1};

  char_row_t directed_rows [22] = '{
    '{ChUpA,   1'b0, 1'b0, NoResult},
    '{"1",     1'b1, 1'b0, NoResult},
    '{"2",     1'b0, 1'b0, NoResult},
    '{ChNul,   1'b0, 1'b1, '{64'd12, 16'd2, 1'b0, 1'b0}},
    '{ChSpace, 1'b1, 1'b0, NoResult},
    '{ChMinus, 1'b0, 1'b0, NoResult},
    '{"7",     1'b0, 1'b0, NoResult},
    '{8'hFF,   1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFF9, 16'd3, 1'b0, 1'b0}},
    '{"5",     1'b1, 1'b0, NoResult},
    '{"9",     1'b1, 1'b0, NoResult},
    '{";",     1'b0, 1'b1, '{64'd9, 16'd1, 1'b0, 1'b0}},
    '{ChPlus,  1'b1, 1'b0, NoResult},
    '{ChCr,    1'b0, 1'b0, NoResult},
    '{ChMinus, 1'b0, 1'b1, '{64'd0, 16'd0, 1'b0, 1'b1}},
    '{8'hFF,   1'b1, 1'b1, '{64'd0, 16'd0, 1'b0, 1'b1}},
    '{ChZero,  1'b1, 1'b0, NoResult},
    '{ChZero,  1'b0, 1'b0, NoResult},
    '{"9",     1'b0, 1'b0, NoResult},
    '{ChNul,   1'b0, 1'b1, '{64'd9, 16'd3, 1'b0, 1'b0}},
    '{ChTab,   1'b1, 1'b0, NoResult},
    '{"8",     1'b0, 1'b0, NoResult},
    '{"a",     1'b0, 1'b1, '{64'd8, 16'd2, 1'b0, 1'b0}}
  };

  function automatic logic blank_char_p(input logic [ChW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic int digit_value(input logic [ChW-1:0] c);
    if ((c >= ChZero) && (c <= ChNine)) return int'(c - ChZero);
    if ((c >= ChLowA) && (c <= ChLowZ)) return int'(c - ChLowA) + 10;
    if ((c >= ChUpA) && (c <= ChUpZ)) return int'(c - ChUpA) + 10;
    return int'(NoDigit);
  endfunction

  task automatic count_char();
    if (prs_count != '1) prs_count = prs_count + 1'b1;
  endtask

  task automatic clear_number();
    prs_acc = '0;
    prs_over = 1'b0;
    prs_neg = 1'b0;
    prs_base = Base10;
    prs_count = '0;
    prs_digit = 1'b0;
  endtask

  task automatic finish_number(input logic drop_last, output res_t r);
    logic [ValueW-1:0] v;
    logic [ConsumedW-1:0] c;
    v = prs_acc;
    c = '0;
    if (prs_digit) begin
      c = prs_count;
      if (drop_last && (c != '1) && (c != '0)) c = c - 1'b1;
    end
    if (prs_over) begin
      v = signed_reg ? (prs_neg ? SignedMin : SignedMax) : UnsMax;
    end else if (prs_neg) begin
      v = -v;
    end
    r.value = v;
    r.consumed = c;
    r.overflowed = prs_over;
    r.no_digits = !prs_digit;
    prs_phase = PhIdle;
  endtask

  task automatic take_digit(input logic [ChW-1:0] c, output logic got, output res_t r);
    int d;
    logic [ValueW-1:0] lim;
    d = digit_value(c);
    got = 1'b0;
    r = NoResult;
    if ((d >= int'(prs_base)) || (prs_base < 2)) begin
      finish_number(1'b0, r);
      got = 1'b1;
      return;
    end
    lim = signed_reg ? (prs_neg ? SignedMin : SignedMax) : UnsMax;
    if (prs_acc > (lim - ValueW'(d)) / ValueW'(prs_base)) begin
      prs_over = 1'b1;
    end else if (!prs_over) begin
      prs_acc = prs_acc * ValueW'(prs_base) + ValueW'(d);
    end
    prs_digit = 1'b1;
    count_char();
  endtask

  task automatic begin_number(input logic [ChW-1:0] c, output logic got, output res_t r);
    got = 1'b0;
    r = NoResult;
    if ((radix_reg == RadixOne) || (radix_reg > RadixMax)) begin
      finish_number(1'b0, r);
      got = 1'b1;
      return;
    end
    if ((c == ChZero) && ((radix_reg == RadixAuto) || (radix_reg == Base16))) begin
      prs_base = (radix_reg == RadixAuto) ? Base8 : Base16;
      prs_acc = '0;
      prs_digit = 1'b1;
      count_char();
      prs_phase = PhZero;
      return;
    end
    prs_base = (radix_reg == RadixAuto) ? Base10 : radix_reg;
    prs_phase = PhDigits;
    take_digit(c, got, r);
  endtask

  task automatic parse_char(input logic [ChW-1:0] c, input logic f, output logic took,
                            output logic got, output res_t r);
    took = 1'b1;
    got = 1'b0;
    r = NoResult;
    if (f) begin
      clear_number();
      prs_phase = PhWs1;
    end else if (prs_phase == PhIdle) begin
      took = 1'b0;
      return;
    end
    case (prs_phase)
      PhWs1: begin
        if (blank_char_p(c)) begin
          count_char();
        end else if ((c == ChPlus) || (c == ChMinus)) begin
          prs_neg = (c == ChMinus);
          count_char();
          prs_phase = PhWs2;
        end else begin
          begin_number(c, got, r);
        end
      end
      PhWs2: begin
        if (blank_char_p(c)) count_char();
        else begin_number(c, got, r);
      end
      PhZero: begin
        if ((c == ChLowX) || (c == ChUpX)) begin
          count_char();
          prs_phase = PhZeroX;
        end else begin
          prs_phase = PhDigits;
          take_digit(c, got, r);
        end
      end
      PhZeroX: begin
        if (digit_value(c) < 16) begin
          prs_base = Base16;
          prs_phase = PhDigits;
          take_digit(c, got, r);
        end else begin
          finish_number(1'b1, r);
          got = 1'b1;
        end
      end
      PhDigits: take_digit(c, got, r);
      default: prs_phase = PhIdle;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_number();
    res_t want;
    if (expected_numbers.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction value %h", res_bus.value));
      return;
    end
    want = expected_numbers.pop_front();
    if (res_bus.value !== want.value)
      report_mismatch($sformatf("value %h, want %h", res_bus.value, want.value));
    if (res_bus.consumed !== want.consumed)
      report_mismatch($sformatf("consumed %0d, want %0d", res_bus.consumed, want.consumed));
    if (res_bus.overflowed !== want.overflowed)
      report_mismatch($sformatf("overflowed %b, want %b", res_bus.overflowed,
                                want.overflowed));
    if (res_bus.no_digits !== want.no_digits)
      report_mismatch($sformatf("no_digits %b, want %b", res_bus.no_digits, want.no_digits));
  endtask

  task automatic send_char(input logic [ChW-1:0] c, input logic f, input logic typed,
                           input res_t want);
    logic took;
    logic got;
    res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      chr_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    chr_bus.valid <= 1'b1;
    chr_bus.ch <= c;
    chr_bus.first <= f;
    @(posedge clk);
    while (!chr_bus.ready) @(posedge clk);
    parse_char(c, f, took, got, r);
    if (typed) expected_numbers.push_back(want);
    else if (got) expected_numbers.push_back(r);
    if (took) chars_parsed++;
  endtask

  function automatic logic [ChW-1:0] blank_pick();
    if ($urandom_range(5) == 5) return ChSpace;
    return ChTab + ChW'($urandom_range(4));
  endfunction

  function automatic logic [ChW-1:0] digit_char(input int v);
    if (v < 10) return ChZero + ChW'(v);
    return ($urandom_range(1) ? ChLowA : ChUpA) + ChW'(v - 10);
  endfunction

  task automatic send_number_text();
    logic [ChW-1:0] txt[$];
    int gen_base;
    int ndig;
    int pattern;
    int v;
    int roll;
    if ((radix_reg >= 2) && (radix_reg <= RadixMax)) gen_base = int'(radix_reg);
    else if (radix_reg == RadixAuto) gen_base = $urandom_range(1) ? 16 : 10;
    else gen_base = 36;
    repeat ($urandom_range(0, 2)) txt.push_back(blank_pick());
    if ($urandom_range(99) < 45) txt.push_back($urandom_range(1) ? ChMinus : ChPlus);
    if ($urandom_range(99) < 20) txt.push_back(blank_pick());
    if ($urandom_range(99) < 5) txt.push_back($urandom_range(1) ? ChMinus : ChPlus);
    if ($urandom_range(99) < 35) begin
      txt.push_back(ChZero);
      if ($urandom_range(99) < 60) txt.push_back($urandom_range(1) ? ChLowX : ChUpX);
    end
    roll = $urandom_range(99);
    if (roll < 5) ndig = 0;
    else if (roll < 75) ndig = $urandom_range(1, 6);
    else if (roll < 90) ndig = $urandom_range(7, 14);
    else ndig = $urandom_range(15, 70);
    pattern = $urandom_range(9);
    for (int i = 0; i < ndig; i++) begin
      if (pattern == 0) v = gen_base - 1;
      else if (pattern == 1) v = (i == 0) ? 1 : 0;
      else v = $urandom_range(gen_base - 1);
      txt.push_back(digit_char(v));
    end
    case ($urandom_range(3))
      0: txt.push_back(ChNul);
      1: txt.push_back(ChW'($urandom_range(255)));
      2: txt.push_back((gen_base < 36) ? digit_char(gen_base) : ChNul);
      default: txt.push_back($urandom_range(1) ? blank_pick() : ChMinus);
    endcase
    foreach (txt[i]) send_char(txt[i], i == 0, 1'b0, NoResult);
    if ($urandom_range(99) < 10) send_char(ChW'($urandom_range(255)), 1'b0, 1'b0, NoResult);
  endtask

  task automatic send_noise();
    logic f;
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      f = (i == 0) ? ($urandom_range(99) < 70) : ($urandom_range(99) < 10);
      send_char(ChW'($urandom_range(255)), f, 1'b0, NoResult);
    end
  endtask

  task automatic drain_results();
    chr_bus.valid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(input int r, input int s);
    cfg_we <= 1'b1;
    cfg_idx <= RegRadix;
    cfg_data <= BaseW'(r);
    @(posedge clk);
    cfg_idx <= RegSigned;
    cfg_data <= BaseW'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_reg = BaseW'(r);
    signed_reg = s[0];
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("[text_to_integer_parser] ERROR");
    $finish;
  end

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) check_number();
      res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int start_count;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= RegRadix;
    cfg_data <= '0;
    chr_bus.valid <= 1'b0;
    chr_bus.ch <= ChNul;
    chr_bus.first <= 1'b0;
    mismatches = 0;
    chars_parsed = 0;
    send_idle_pct = 32;
    recv_stall_pct = 32;
    radix_reg = RadixReset;
    signed_reg = 1'b0;
    prs_phase = PhIdle;
    clear_number();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].first, directed_rows[i].typed,
                directed_rows[i].want);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_config(radix_plan[p], signed_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (p == 0) begin
        // end on a prefix with no hex digit
        send_char(ChSpace, 1'b1, 1'b0, NoResult);
        send_char(ChZero, 1'b0, 1'b0, NoResult);
        send_char(ChLowX, 1'b0, 1'b0, NoResult);
        send_char("g", 1'b0, 1'b0, NoResult);
      end
      start_count = chars_parsed;
      while (chars_parsed - start_count < CharsPerPhase) begin
        if ($urandom_range(99) < 80) send_number_text();
        else send_noise();
      end
    end

    drain_results();
    if (mismatches == 0 && expected_numbers.size() == 0) begin
      $display("[text_to_integer_parser] OK");
    end else begin
      $display("[text_to_integer_parser] ERROR");
    end
    $finish;
  end

endmodule
